FILE: rtl/core/fxalu_pkg.sv
// ============================================================================
// fxalu_pkg: shared definitions for the Q24.8 fixed-point ALU
// Operation codes, widths and the record that moves down the pipeline.
// ============================================================================
package fxalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    // Bits of the shifted dividend, and so the number of divider cells.
    localparam int NUM_W     = WORD_W + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } alu_op_t;

    // One item in flight. For divides, rem and numq carry the restoring
    // division state; numq shifts dividend bits out and quotient bits in.
    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic              neg;
        logic              cmp;
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] den;
        logic [WORD_W-1:0] rem;
        logic [NUM_W-1:0]  numq;
    } stage_t;

endpackage

FILE: rtl/core/fxalu_front.sv
// ============================================================================
// fxalu_front: operand decode stage
// Computes every operation but the divide, including the multiply, and
// prepares the magnitudes and sign for the divider chain.
// ============================================================================
module fxalu_front
    import fxalu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        in_operation,
    input  logic [WORD_W-1:0] in_operand_a,
    input  logic [WORD_W-1:0] in_operand_b,
    output logic              out_valid,
    input  logic              out_ready,
    output stage_t            out_data
);

    logic                   valid_reg;
    stage_t                 data_reg;
    stage_t                 data_next;
    alu_op_t                op;
    logic signed [WORD_W-1:0]   sa;
    logic signed [WORD_W-1:0]   sb;
    logic signed [2*WORD_W-1:0] product;
    logic                   a_lt_b;
    logic                   a_gt_b;
    logic [WORD_W-1:0]      mag_a;
    logic [WORD_W-1:0]      mag_b;

    assign op      = alu_op_t'(in_operation);
    assign sa      = $signed(in_operand_a);
    assign sb      = $signed(in_operand_b);
    assign product = (2*WORD_W)'(sa) * (2*WORD_W)'(sb);
    assign a_lt_b  = sa < sb;
    assign a_gt_b  = sa > sb;
    assign mag_a   = in_operand_a[WORD_W-1] ? (WORD_W'(0) - in_operand_a) : in_operand_a;
    assign mag_b   = in_operand_b[WORD_W-1] ? (WORD_W'(0) - in_operand_b) : in_operand_b;

    always_comb begin
        data_next        = '0;
        data_next.den    = mag_b;
        data_next.numq   = {mag_a, FRAC_BITS'(0)};
        data_next.neg    = in_operand_a[WORD_W-1] ^ in_operand_b[WORD_W-1];
        case (op)
            OP_ADD:      data_next.res = in_operand_a + in_operand_b;
            OP_SUB:      data_next.res = in_operand_a - in_operand_b;
            OP_MUL:      data_next.res = product[FRAC_BITS +: WORD_W];
            OP_DIV: begin
                data_next.is_div = 1'b1;
                data_next.dz     = (in_operand_b == '0);
            end
            OP_GT:       data_next.cmp = a_gt_b;
            OP_LT:       data_next.cmp = a_lt_b;
            OP_GE:       data_next.cmp = !a_lt_b;
            OP_LE:       data_next.cmp = !a_gt_b;
            OP_EQ:       data_next.cmp = (in_operand_a == in_operand_b);
            OP_NE:       data_next.cmp = (in_operand_a != in_operand_b);
            OP_MIN:      data_next.res = a_lt_b ? in_operand_a : in_operand_b;
            OP_MAX:      data_next.res = a_gt_b ? in_operand_a : in_operand_b;
            OP_INC:      data_next.res = in_operand_a + WORD_W'(1);
            OP_DEC:      data_next.res = in_operand_a - WORD_W'(1);
            OP_TO_INT:   data_next.res = WORD_W'(sa >>> FRAC_BITS);
            OP_FROM_INT: data_next.res = in_operand_a << FRAC_BITS;
            default:     data_next.res = '0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/fxalu_cell.sv
// ============================================================================
// fxalu_cell: one restoring division step
// Brings in one dividend bit, subtracts the divisor when it fits and shifts
// the quotient bit in; other items keep their result fields unchanged.
// ============================================================================
module fxalu_cell
    import fxalu_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    logic            valid_reg;
    stage_t          data_reg;
    stage_t          data_next;
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    logic            fits;

    assign trial = {in_data.rem, in_data.numq[NUM_W-1]};
    assign diff  = trial - {1'b0, in_data.den};
    assign fits  = trial >= {1'b0, in_data.den};

    always_comb begin
        data_next      = in_data;
        data_next.rem  = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        data_next.numq = {in_data.numq[NUM_W-2:0], fits};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A held item must not change while the next cell is full.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("division cell changed a stalled item");

    // For a divide with a nonzero divisor, the partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg.is_div && !data_reg.dz |-> data_reg.rem < data_reg.den)
        else $error("partial remainder not below divisor");

    // The zero-divisor flag only travels with a divide whose divisor is zero.
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg.dz |-> data_reg.is_div && data_reg.den == '0)
        else $error("zero-divisor flag on an item with a nonzero divisor");

endmodule

FILE: rtl/core/fxalu_back.sv
// ============================================================================
// fxalu_back: result stage and output register
// Applies the quotient sign and the zero-divisor rule, and holds the result
// until the consumer takes it.
// ============================================================================
module fxalu_back
    import fxalu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  stage_t            in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_result_word,
    output logic              out_compare_true,
    output logic              out_divide_by_zero
);

    logic              valid_reg;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] result_next;
    logic              cmp_reg;
    logic              dz_reg;
    logic [WORD_W-1:0] quot;

    assign quot = in_data.numq[WORD_W-1:0];

    always_comb begin
        if (in_data.is_div) begin
            if (in_data.dz) begin
                result_next = '0;
            end else begin
                result_next = in_data.neg ? (WORD_W'(0) - quot) : quot;
            end
        end else begin
            result_next = in_data.res;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
            cmp_reg    <= in_data.cmp;
            dz_reg     <= in_data.dz;
        end
    end

    assign out_valid          = valid_reg;
    assign out_result_word    = result_reg;
    assign out_compare_true   = cmp_reg;
    assign out_divide_by_zero = dz_reg;

endmodule

FILE: rtl/core/fixed_point_q24_8_alu.sv
// ============================================================================
// fixed_point_q24_8_alu: signed Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max, inc/dec and integer
// conversions on 32-bit raw words, built as a pipeline of division cells.
// ============================================================================
// Structure: one decode stage, one cell per dividend bit and one output
// register. Every operation takes the same path, so results leave in order.
// Throughput: one transfer per cycle unless m_ready stalls the output;
// each stage holds one item.
// Reset: aresetn (synchronous, active low) empties every stage.
module fixed_point_q24_8_alu
    import fxalu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_operation,
    input  logic [WORD_W-1:0] s_operand_a,
    input  logic [WORD_W-1:0] s_operand_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_result_word,
    output logic              m_compare_true,
    output logic              m_divide_by_zero
);

    // Stage k of the chain is the output of the decode stage (k = 0) or of
    // cell k-1. Each stage loads whenever it is empty or its successor loads,
    // so bubbles anywhere in the chain are filled while a result waits.
    stage_t chain_data  [NUM_W+1];
    logic   chain_valid [NUM_W+1];
    logic   chain_ready [NUM_W+1];

    // The decode stage computes every operation but the divide, including the
    // multiply, and sets up divisor and dividend magnitudes for the cells.
    fxalu_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_operation (s_operation),
        .in_operand_a (s_operand_a),
        .in_operand_b (s_operand_b),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_data     (chain_data[0])
    );

    // One restoring division step per cell, most significant dividend bit
    // first. Non-divide items ride along with their result already settled.
    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        fxalu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // The result stage fixes the quotient sign and owns the output register.
    fxalu_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (chain_valid[NUM_W]),
        .in_ready           (chain_ready[NUM_W]),
        .in_data            (chain_data[NUM_W]),
        .out_valid          (m_valid),
        .out_ready          (m_ready),
        .out_result_word    (m_result_word),
        .out_compare_true   (m_compare_true),
        .out_divide_by_zero (m_divide_by_zero)
    );

    // A divide by zero reports a zero word and no comparison outcome.
    a_dz_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_result_word == '0 && !m_compare_true)
        else $error("divide by zero returned a nonzero result");

    // With the output register empty every stage can move, so input is open.
    a_open_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output register");

    // A stalled result leaves the chain stalled behind a full output stage.
    a_stall_path: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !chain_ready[NUM_W])
        else $error("result stage loaded over a waiting result");

endmodule

FILE: tb/sv/tb_fixed_point_q24_8_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu: self-checking testbench for the Q24.8 fixed-point ALU
// Drives a short directed table and then a long random stream of operations
// through the valid/ready input. Every result transfer is checked field by
// field against the table or a behavioral model. Both sides idle and stall at
// random, and once the receiver holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu;
    import fxalu_pkg::*;

    // Corner words of the 32-bit raw format. One is 1.0 with eight fraction bits.
    localparam logic [WORD_W-1:0] W_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] W_MAX  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] W_NEG1 = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] W_ONE  = 32'h0000_0100;

    localparam int NUM_DIRECTED   = 25;
    localparam int TOTAL_ITEMS    = 1850;
    localparam int RANDOM_ITEMS   = TOTAL_ITEMS - NUM_DIRECTED;
    // Wait after the last result, longer than the pipeline is deep.
    localparam int DRAIN_CYCLES   = 60;
    // The long receiver hold-off, well beyond the pipeline depth.
    localparam int PRESSURE_HOLD  = 300;
    localparam int PRESSURE_AFTER = 600;
    // Worst legal quiet stretch is the pressure hold; allow it many times over.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 40;

    // One result as it leaves the block.
    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic              compare_true;
        logic              divide_by_zero;
    } alu_result_t;

    // One row of the directed table. When given is set, the row carries its
    // own expected result; otherwise the model computes it.
    typedef struct packed {
        alu_op_t           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              given;
        alu_result_t       want;
    } stim_row_t;

    localparam alu_result_t MODEL = '0;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [3:0]        s_operation;
    logic [WORD_W-1:0] s_operand_a;
    logic [WORD_W-1:0] s_operand_b;
    logic              m_valid;
    logic              m_ready;
    logic [WORD_W-1:0] m_result_word;
    logic              m_compare_true;
    logic              m_divide_by_zero;

    // Expected results in issue order; the block keeps results in order.
    alu_result_t pending_results [$];

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned div_zero_seen   = 0;
    int unsigned compares_held   = 0;
    int unsigned input_stalls    = 0;
    bit [15:0]   ops_seen        = '0;

    // Sender pacing: a run of back-to-back items, counted down per item.
    int unsigned send_steady_left = 0;

    // Directed table: wrap-around at the edges of the word, every operation,
    // division by zero, rounding of multiply and to_int toward minus infinity,
    // divide truncation toward zero, and comparisons leaving the word at zero.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_ADD,      W_MAX,          32'd1,          1'b1, '{W_MIN, 1'b0, 1'b0}},
        '{OP_ADD,      W_MIN,          W_NEG1,         1'b1, '{W_MAX, 1'b0, 1'b0}},
        '{OP_SUB,      W_MIN,          32'd1,          1'b1, '{W_MAX, 1'b0, 1'b0}},
        '{OP_MUL,      W_ONE,          32'h0000_0300,  1'b1, '{32'h0000_0300, 1'b0, 1'b0}},
        '{OP_MUL,      W_MAX,          W_MAX,          1'b0, MODEL},
        '{OP_MUL,      W_MIN,          W_MIN,          1'b0, MODEL},
        '{OP_MUL,      W_NEG1,         32'd1,          1'b0, MODEL},
        '{OP_DIV,      32'h0000_0300,  32'd0,          1'b1, '{32'd0, 1'b0, 1'b1}},
        '{OP_DIV,      W_MIN,          32'd0,          1'b1, '{32'd0, 1'b0, 1'b1}},
        '{OP_DIV,      W_MIN,          W_NEG1,         1'b0, MODEL},
        '{OP_DIV,      W_ONE,          32'h0000_0300,  1'b0, MODEL},
        '{OP_DIV,      32'hffff_ff00,  32'h0000_0300,  1'b0, MODEL},
        '{OP_GT,       W_MAX,          W_MIN,          1'b1, '{32'd0, 1'b1, 1'b0}},
        '{OP_LT,       W_MAX,          W_MIN,          1'b1, '{32'd0, 1'b0, 1'b0}},
        '{OP_GE,       32'd5,          32'd5,          1'b1, '{32'd0, 1'b1, 1'b0}},
        '{OP_LE,       W_MIN,          W_MAX,          1'b1, '{32'd0, 1'b1, 1'b0}},
        '{OP_EQ,       W_MIN,          W_MIN,          1'b1, '{32'd0, 1'b1, 1'b0}},
        '{OP_NE,       W_MIN,          W_MAX,          1'b1, '{32'd0, 1'b1, 1'b0}},
        '{OP_MIN,      W_MIN,          W_MAX,          1'b1, '{W_MIN, 1'b0, 1'b0}},
        '{OP_MAX,      W_MIN,          W_MAX,          1'b1, '{W_MAX, 1'b0, 1'b0}},
        '{OP_INC,      W_MAX,          W_NEG1,         1'b1, '{W_MIN, 1'b0, 1'b0}},
        '{OP_DEC,      W_MIN,          W_NEG1,         1'b1, '{W_MAX, 1'b0, 1'b0}},
        '{OP_TO_INT,   W_NEG1,         32'd0,          1'b1, '{W_NEG1, 1'b0, 1'b0}},
        '{OP_TO_INT,   W_MIN,          W_MAX,          1'b0, MODEL},
        '{OP_FROM_INT, W_MAX,          32'd0,          1'b1, '{32'hffff_ff00, 1'b0, 1'b0}}
    };

    fixed_point_q24_8_alu dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_word    (m_result_word),
        .m_compare_true   (m_compare_true),
        .m_divide_by_zero (m_divide_by_zero)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Behavioral model of one ALU operation. All word results wrap to 32 bits.
    function automatic alu_result_t fx_alu_result(input alu_op_t op,
                                                  input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic signed [WORD_W-1:0] sa;
        logic signed [WORD_W-1:0] sb;
        logic signed [63:0]       wa;
        logic signed [63:0]       wb;
        logic signed [63:0]       product;
        logic [63:0]              mag_a;
        logic [63:0]              mag_b;
        logic [63:0]              quot;
        alu_result_t              r;
        sa = a;
        sb = b;
        wa = sa;
        wb = sb;
        r  = '0;
        case (op)
            OP_ADD: r.result_word = a + b;
            OP_SUB: r.result_word = a - b;
            OP_MUL: begin
                // Full signed product, then an arithmetic shift: floors toward minus infinity.
                product = wa * wb;
                product = product >>> FRAC_BITS;
                r.result_word = product[WORD_W-1:0];
            end
            OP_DIV: begin
                if (b == '0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    // Divide magnitudes so the quotient truncates toward zero.
                    mag_a = (sa < 0) ? -wa : wa;
                    mag_b = (sb < 0) ? -wb : wb;
                    quot  = (mag_a << FRAC_BITS) / mag_b;
                    if ((sa < 0) != (sb < 0)) begin
                        quot = -quot;
                    end
                    r.result_word = quot[WORD_W-1:0];
                end
            end
            OP_GT:       r.compare_true = (sa >  sb);
            OP_LT:       r.compare_true = (sa <  sb);
            OP_GE:       r.compare_true = (sa >= sb);
            OP_LE:       r.compare_true = (sa <= sb);
            OP_EQ:       r.compare_true = (sa == sb);
            OP_NE:       r.compare_true = (sa != sb);
            OP_MIN:      r.result_word = (sa < sb) ? a : b;
            OP_MAX:      r.result_word = (sa > sb) ? a : b;
            OP_INC:      r.result_word = a + 32'd1;
            OP_DEC:      r.result_word = a - 32'd1;
            OP_TO_INT:   r.result_word = sa >>> FRAC_BITS;
            OP_FROM_INT: r.result_word = a << FRAC_BITS;
            default:     r = '0;
        endcase
        return r;
    endfunction

    // Operands are drawn from several pools so that corners, small values and
    // whole numbers come up often next to fully random words.
    function automatic logic [WORD_W-1:0] random_operand();
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 2047) - 1024;
            1: begin
                case ($urandom_range(0, 5))
                    0: v = W_MIN;
                    1: v = W_MAX;
                    2: v = '0;
                    3: v = W_ONE;
                    4: v = W_NEG1;
                    default: v = W_MIN + 32'd1;
                endcase
            end
            2: v = ($urandom_range(0, 255) - 128) << FRAC_BITS;
            3: v = {{16{r[15]}}, r[15:0]};
            default: v = r;
        endcase
        return v;
    endfunction

    // Each failure prints one line, up to a cap, and is always counted.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Offers one item and holds it until the transfer happens. The expected
    // result is queued at the accepting edge.
    task automatic send_item(input alu_op_t op, input logic [WORD_W-1:0] a,
                             input logic [WORD_W-1:0] b, input alu_result_t want);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(want);
        ops_seen[op] = 1'b1;
        items_sent++;
    endtask

    // Random gap after a transfer: mostly none, sometimes a few cycles, rarely
    // a long one, with runs of back-to-back items in between.
    task automatic pause_sender();
        int unsigned gap;
        int unsigned pick;
        gap = 0;
        if (send_steady_left > 0) begin
            send_steady_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_steady_left = $urandom_range(20, 100);
            end else if (pick < 30) begin
                gap = $urandom_range(1, 3);
            end else if (pick < 33) begin
                gap = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stimulus: reset, the directed table, then the random stream, then drain.
    initial begin : stimulus
        int unsigned       n;
        alu_op_t           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        s_valid     <= 1'b0;
        s_operation <= OP_ADD;
        s_operand_a <= '0;
        s_operand_b <= '0;
        aresetn     <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Rows with a value given are checked against that value; the rest
        // go through the model.
        for (n = 0; n < NUM_DIRECTED; n++) begin
            send_item(directed_rows[n].op, directed_rows[n].a, directed_rows[n].b,
                      directed_rows[n].given ? directed_rows[n].want
                      : fx_alu_result(directed_rows[n].op, directed_rows[n].a,
                                      directed_rows[n].b));
            pause_sender();
        end

        // Random stream. Divides see a zero divisor now and then, and the
        // comparisons and min/max often get equal operands.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            op = alu_op_t'($urandom_range(0, 15));
            a  = random_operand();
            b  = random_operand();
            if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
                b = '0;
            end else if (op >= OP_GT && op <= OP_MAX && $urandom_range(0, 3) == 0) begin
                b = a;
            end
            send_item(op, a, b, fx_alu_result(op, a, b));
            pause_sender();
        end
        s_valid <= 1'b0;

        // Wait for every outstanding result, then a little past the latency
        // so that any stray transfer is caught.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Coverage: %0d items sent, %0d results checked, %0d of 16 operations.",
                 items_sent, results_checked, $countones(ops_seen));
        $display("Coverage: %0d divides by zero, %0d comparisons true, %0d input stall cycles.",
                 div_zero_seen, compares_held, input_stalls);
        if (error_count == 0) begin
            $display("tb_fixed_point_q24_8_alu: done, clean");
        end else begin
            $display("tb_fixed_point_q24_8_alu: done, errors");
        end
        $finish;
    end

    // Receiver: random ready with short and long stalls and steady runs. Once,
    // after enough results, it holds off long enough for the pipeline to fill
    // and push back on the input.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned steady_left;
        int unsigned pick;
        bit          pressure_done;
        hold_left     = 0;
        steady_left   = 0;
        pressure_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!pressure_done && results_checked >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (steady_left > 0) begin
                m_ready <= 1'b1;
                steady_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    steady_left = $urandom_range(20, 100);
                    m_ready <= 1'b1;
                end else if (pick < 20) begin
                    hold_left = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else if (pick < 23) begin
                    hold_left = $urandom_range(9, 39);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            @(posedge aclk);
        end
    end

    // Checker: every result transfer is matched with the oldest expectation.
    initial begin : result_checker
        alu_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (s_valid && !s_ready) begin
                    input_stalls++;
                end
                if (m_valid === 1'b1 && m_ready) begin
                    if (pending_results.size() == 0) begin
                        report_error($sformatf("result transfer with nothing expected: word %h",
                                               m_result_word));
                    end else begin
                        want = pending_results.pop_front();
                        results_checked++;
                        if (m_result_word !== want.result_word) begin
                            report_error($sformatf("result %0d: result_word %h, expected %h",
                                                   results_checked, m_result_word,
                                                   want.result_word));
                        end
                        if (m_compare_true !== want.compare_true) begin
                            report_error($sformatf("result %0d: compare_true %b, expected %b",
                                                   results_checked, m_compare_true,
                                                   want.compare_true));
                        end
                        if (m_divide_by_zero !== want.divide_by_zero) begin
                            report_error($sformatf("result %0d: divide_by_zero %b, expected %b",
                                                   results_checked, m_divide_by_zero,
                                                   want.divide_by_zero));
                        end
                        if (want.divide_by_zero) begin
                            div_zero_seen++;
                        end
                        if (want.compare_true) begin
                            compares_held++;
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid === 1'b1 && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, pending_results.size());
        $display("tb_fixed_point_q24_8_alu: done, errors");
        $finish;
    end

endmodule
